/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg
// widths, result bundle and calendar helpers for the date add unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 15;
    localparam int DOY_W   = 9;
    localparam int ALU_W   = 16;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [8:0]         CYCLE_400   = 9'd400;

    // one finished date
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               invalid;
    } gdad_result_t;

    // flags from the shared adder
    typedef struct packed {
        logic neg;
        logic zero;
    } gdad_alu_flags_t;

    // leap test from the year modulo 400
    function automatic logic is_leap(input logic [8:0] r400);
        logic by4;
        logic by100;
        by4   = (r400[1:0] == 2'd0);
        by100 = (r400 == 9'd0) || (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (r400 == 9'd0) || (by4 && !by100);
    endfunction

    // month length, zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gdad_req_if.sv */
// ----------------------------------------------------------------------------
// gdad_req_if
// start date and day count channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gdad_req_if;
    import gdad_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [COUNT_W-1:0] days_to_add;

    modport source (output valid, output start_year, output start_month,
                    output start_day, output days_to_add, input ready);
    modport sink   (input valid, input start_year, input start_month,
                    input start_day, input days_to_add, output ready);
endinterface

`default_nettype wire

/* rtl/core/gdad_rsp_if.sv */
// ----------------------------------------------------------------------------
// gdad_rsp_if
// result date channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gdad_rsp_if;
    import gdad_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               start_invalid;

    modport source (output valid, output result_year, output result_month,
                    output result_day, output start_invalid, input ready);
    modport sink   (input valid, input result_year, input result_month,
                    input result_day, input start_invalid, output ready);
endinterface

`default_nettype wire

/* rtl/core/gdad_alu.sv */
// ----------------------------------------------------------------------------
// gdad_alu
// shared add-subtract unit: a + b - c with sign and zero flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdad_alu (
    input  wire logic [gdad_pkg::ALU_W-1:0] a,
    input  wire logic [gdad_pkg::ALU_W-1:0] b,
    input  wire logic [gdad_pkg::ALU_W-1:0] c,
    output logic [gdad_pkg::ALU_W:0]        res,
    output gdad_pkg::gdad_alu_flags_t       flags
);
    import gdad_pkg::*;

    // operands stay below 2^15, so the top bit is a true sign
    assign res        = {1'b0, a} + {1'b0, b} - {1'b0, c};
    assign flags.neg  = res[ALU_W];
    assign flags.zero = (res == '0);

endmodule

`default_nettype wire

/* rtl/core/gdad_seq.sv */
// ----------------------------------------------------------------------------
// gdad_seq
// sequencer and working registers; drives the shared adder step by step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdad_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    gdad_req_if.sink              req,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output gdad_pkg::gdad_result_t res
);
    import gdad_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MOD   = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_YEAR  = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_SPLIT = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [YEAR_W-1:0]  rem_reg, rem_next;
    logic [DOY_W-1:0]   doy_reg, doy_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [2:0]         step_reg, step_next;
    logic               invalid_reg, invalid_next;
    logic [MONTH_W-1:0] res_month_reg, res_month_next;
    logic [DAY_W-1:0]   res_day_reg, res_day_next;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_c;
    logic [ALU_W:0]     alu_res;
    gdad_alu_flags_t    alu_flags;

    logic               leap;
    logic [DOY_W-1:0]   year_len;
    logic [DAY_W-1:0]   walk_len;
    logic [DAY_W-1:0]   start_len;
    logic               start_ok;

    gdad_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .res   (alu_res),
        .flags (alu_flags)
    );

    // calendar facts for the current year
    assign leap      = is_leap(rem_reg[8:0]);
    assign year_len  = leap ? 9'd366 : 9'd365;
    assign walk_len  = month_len(leap, m_reg);
    assign start_len = month_len(leap, month_reg);
    assign start_ok  = (start_len != 5'd0) && (day_reg != 5'd0) && (day_reg <= start_len);

    // operand select for the shared adder
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
        case (state_reg)
            S_MOD:
            begin
                alu_a = ALU_W'(rem_reg);
                alu_c = ALU_W'(CYCLE_400) << step_reg;
            end
            S_WALK:
            begin
                alu_a = ALU_W'(doy_reg);
                alu_b = ALU_W'(walk_len);
            end
            S_YEAR:
            begin
                alu_a = ALU_W'(count_reg);
                alu_b = ALU_W'(doy_reg);
                alu_c = ALU_W'(year_len);
            end
            S_FIN:
            begin
                alu_a = ALU_W'(doy_reg);
                alu_b = ALU_W'(count_reg);
            end
            S_SPLIT:
            begin
                alu_a = ALU_W'(doy_reg);
                alu_c = ALU_W'(walk_len);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        doy_next       = doy_reg;
        m_next         = m_reg;
        step_next      = step_reg;
        invalid_next   = invalid_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    year_next  = req.start_year;
                    month_next = req.start_month;
                    day_next   = req.start_day;
                    count_next = req.days_to_add;
                    rem_next   = req.start_year;
                    step_next  = 3'd5;
                    state_next = S_MOD;
                end
            end
            // restoring reduction of the year modulo 400
            S_MOD:
            begin
                if (!alu_flags.neg)
                begin
                    rem_next = alu_res[YEAR_W-1:0];
                end
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    state_next = S_CHK;
                end
            end
            // validate the start date
            S_CHK:
            begin
                invalid_next = !start_ok;
                doy_next     = start_ok ? DOY_W'(day_reg) : '0;
                m_next       = MONTH_FIRST;
                state_next   = start_ok ? S_WALK : S_YEAR;
            end
            // add lengths of the months before the start month
            S_WALK:
            begin
                if (m_reg == month_reg)
                begin
                    state_next = S_YEAR;
                end
                else
                begin
                    doy_next = alu_res[DOY_W-1:0];
                    m_next   = m_reg + 4'd1;
                end
            end
            // step whole years while the count exceeds the days left
            S_YEAR:
            begin
                if (!alu_flags.neg && !alu_flags.zero)
                begin
                    count_next = alu_res[COUNT_W-1:0];
                    year_next  = year_reg + 14'd1;
                    rem_next   = (rem_reg == YEAR_W'(399)) ? '0 : rem_reg + 14'd1;
                    doy_next   = '0;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            // final day of year
            S_FIN:
            begin
                doy_next   = alu_res[DOY_W-1:0];
                m_next     = MONTH_FIRST;
                state_next = S_SPLIT;
            end
            // split the day of year into month and day
            S_SPLIT:
            begin
                if (!alu_flags.neg && !alu_flags.zero && (m_reg != MONTH_LAST))
                begin
                    doy_next = alu_res[DOY_W-1:0];
                    m_next   = m_reg + 4'd1;
                end
                else
                begin
                    res_month_next = m_reg;
                    res_day_next   = doy_reg[DAY_W-1:0];
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        count_reg     <= count_next;
        rem_reg       <= rem_next;
        doy_reg       <= doy_next;
        m_reg         <= m_next;
        step_reg      <= step_next;
        invalid_reg   <= invalid_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.year    = year_reg;
    assign res.month   = res_month_reg;
    assign res.day     = res_day_reg;
    assign res.invalid = invalid_reg;

endmodule

`default_nettype wire

/* rtl/core/gregorian_date_add_days_unit.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// adds a day count to a Gregorian date, one beat at a time
// ----------------------------------------------------------------------------
// The sequencer first reduces the year modulo 400 by restoring subtraction
// and then checks the start date. The month walk adds the length of each
// month before the start month; an invalid start skips it. Year stepping
// moves on one whole year at a time while the count exceeds the days left
// in the year. The final day of year is then formed and split into month
// and day, one month at a time, and the result is handed to the output
// register. The reduction, month walk, year stepping, final day of year and
// split all go through the single shared add-subtract unit. Input ready is
// high only while the sequencer is idle; a finished result moves into the
// output register so a new request can start while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    gdad_req_if.sink  req,
    gdad_rsp_if.source rsp
);
    import gdad_pkg::*;

    logic         seq_valid;
    logic         seq_ready;
    gdad_result_t seq_res;

    logic         out_valid_reg, out_valid_next;
    gdad_result_t out_data_reg, out_data_next;

    gdad_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .res       (seq_res)
    );

    // output register: load when empty or being drained
    assign seq_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (seq_ready)
        begin
            out_valid_next = seq_valid;
            if (seq_valid)
            begin
                out_data_next = seq_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_year   = out_data_reg.year;
    assign rsp.result_month  = out_data_reg.month;
    assign rsp.result_day    = out_data_reg.day;
    assign rsp.start_invalid = out_data_reg.invalid;

endmodule

`default_nettype wire

/* rtl/core/gdad_checker.sv */
// ----------------------------------------------------------------------------
// gdad_checker
// port-level checks on the date add unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gdad_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [3:0] result_month,
    input wire logic [4:0] result_day,
    input wire logic       start_invalid
);

    // a stalled result beat stays offered
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // one item at a time: busy right after a request beat
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // month of a result is always a real month
    `ASSERT_IMPLY(a_month_range, clk, rst_n, rsp_valid,
                  (result_month != 4'd0) && (result_month <= 4'd12))

    // a valid start never yields day zero
    `ASSERT_IMPLY(a_day_nonzero, clk, rst_n, rsp_valid && !start_invalid,
                  result_day != 5'd0)

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .result_month  (rsp.result_month),
    .result_day    (rsp.result_day),
    .start_invalid (rsp.start_invalid)
);

`default_nettype wire

/* tb/tb_gregorian_date_add_days_unit.sv */
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_unit
// self-checking bench for the Gregorian date add unit
// ----------------------------------------------------------------------------
// A short directed table covers the field extremes, the leap rule, invalid
// start dates, zero counts and the last day of a year. Random beats follow.
// Most of them are well-formed dates, some land on year and February edges,
// and the rest are garbage months and days. Each accepted request without a
// typed-in date is run through a local calendar model. The date that comes
// back is compared field by field, in order, with the oldest predicted date.
// Both channels idle at random in three phases: a slow receiver, then a slow
// sender, then full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_unit;
    import gdad_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int DRAIN_CYCLES = 200;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // one request beat
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [COUNT_W-1:0] count;
    } date_req_t;

    // directed row: request, whether the date is typed in, and that date
    typedef struct packed {
        date_req_t    req;
        logic         known;
        gdad_result_t want;
    } directed_row_t;

    localparam int DIRECTED_N = 23;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // valid date, zero count returns it unchanged
        {14'd2024, 4'd3,  5'd15, 15'd0,     1'b1, 14'd2024, 4'd3,  5'd15, 1'b0},
        // lowest year, which is a leap year by the 400 rule
        {14'd0,    4'd1,  5'd1,  15'd0,     1'b1, 14'd0,    4'd1,  5'd1,  1'b0},
        // highest year, last day
        {14'd9999, 4'd12, 5'd31, 15'd0,     1'b1, 14'd9999, 4'd12, 5'd31, 1'b0},
        // highest year and largest count
        {14'd9999, 4'd12, 5'd31, 15'd32767, 1'b0, 24'd0},
        // lowest date and largest count
        {14'd0,    4'd1,  5'd1,  15'd32767, 1'b0, 24'd0},
        // last day of a common year rolls into the next one
        {14'd2023, 4'd12, 5'd31, 15'd1,     1'b1, 14'd2024, 4'd1,  5'd1,  1'b0},
        // last day of a leap year
        {14'd2024, 4'd12, 5'd31, 15'd1,     1'b1, 14'd2025, 4'd1,  5'd1,  1'b0},
        {14'd2023, 4'd12, 5'd31, 15'd365,   1'b0, 24'd0},
        // leap day in a year divisible by 400
        {14'd2000, 4'd2,  5'd29, 15'd0,     1'b1, 14'd2000, 4'd2,  5'd29, 1'b0},
        // leap day in a century year is invalid
        {14'd1900, 4'd2,  5'd29, 15'd0,     1'b1, 14'd1900, 4'd1,  5'd0,  1'b1},
        // century year skips the leap day
        {14'd2100, 4'd2,  5'd28, 15'd1,     1'b1, 14'd2100, 4'd3,  5'd1,  1'b0},
        {14'd2096, 4'd2,  5'd28, 15'd1,     1'b1, 14'd2096, 4'd2,  5'd29, 1'b0},
        // invalid months and days with zero count
        {14'd2023, 4'd0,  5'd10, 15'd0,     1'b1, 14'd2023, 4'd1,  5'd0,  1'b1},
        {14'd2023, 4'd13, 5'd1,  15'd0,     1'b1, 14'd2023, 4'd1,  5'd0,  1'b1},
        {14'd2023, 4'd15, 5'd31, 15'd0,     1'b1, 14'd2023, 4'd1,  5'd0,  1'b1},
        {14'd2023, 4'd4,  5'd31, 15'd0,     1'b1, 14'd2023, 4'd1,  5'd0,  1'b1},
        {14'd2023, 4'd6,  5'd0,  15'd0,     1'b1, 14'd2023, 4'd1,  5'd0,  1'b1},
        // invalid start counts from day zero
        {14'd2023, 4'd0,  5'd0,  15'd1,     1'b1, 14'd2023, 4'd1,  5'd1,  1'b1},
        {14'd2024, 4'd13, 5'd5,  15'd366,   1'b0, 24'd0},
        {14'd2023, 4'd0,  5'd0,  15'd365,   1'b0, 24'd0},
        // month walk across a short February
        {14'd2023, 4'd1,  5'd31, 15'd28,    1'b0, 24'd0},
        // alternating and high bit patterns
        {14'd8191, 4'd7,  5'd15, 15'd16383, 1'b0, 24'd0},
        {14'd5461, 4'd10, 5'd21, 15'd21845, 1'b0, 24'd0}
    };

    logic clk;
    logic rst_n;

    gdad_req_if req_ch ();
    gdad_rsp_if rsp_ch ();

    gdad_result_t pending_dates [$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_idle_pct;

    gregorian_date_add_days_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    always #2 clk = ~clk;

    // calendar model
    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && is_leap_year(y))
            return 29;
        return MONTH_DAYS[m-1];
    endfunction

    function automatic gdad_result_t advance_date(input date_req_t r);
        gdad_result_t res;
        int unsigned  y;
        int unsigned  mon;
        int unsigned  dd;
        int unsigned  doy;
        int unsigned  left;
        int unsigned  remaining;
        int unsigned  len;
        y           = 32'(r.year);
        mon         = 32'(r.month);
        dd          = 32'(r.day);
        left        = 32'(r.count);
        doy         = 0;
        res.invalid = 1'b1;
        // start date to day of year, invalid start stays at day zero
        if (mon >= 1 && mon <= 12 && dd >= 1 && dd <= days_in_month(y, mon))
        begin
            res.invalid = 1'b0;
            for (int unsigned m = 1; m < mon; m++)
                doy += days_in_month(y, m);
            doy += dd;
        end
        // whole years while the count runs past the year end
        remaining = (is_leap_year(y) ? 366 : 365) - doy;
        while (left > remaining)
        begin
            left     -= remaining;
            y++;
            doy       = 0;
            remaining = is_leap_year(y) ? 366 : 365;
        end
        doy += left;
        // split the day of year into month and day
        res.month = MONTH_LAST;
        res.day   = DAY_W'(doy);
        for (int unsigned m = 1; m <= 12; m++)
        begin
            len = days_in_month(y, m);
            if (doy <= len)
            begin
                res.month = MONTH_W'(m);
                res.day   = DAY_W'(doy);
                break;
            end
            doy -= len;
        end
        res.year = YEAR_W'(y);
        return res;
    endfunction

    // random request: mostly well-formed, some edge dates, some garbage
    function automatic date_req_t random_request();
        date_req_t r;
        int        kind;
        kind = int'($urandom_range(0, 99));
        if ($urandom_range(0, 9) < 3)
            r.year = YEAR_W'($urandom_range(0, 99) * 100);
        else
            r.year = YEAR_W'($urandom_range(0, 9999));
        if (kind < 12)
        begin
            r.month = MONTH_W'($urandom_range(0, 15));
            r.day   = DAY_W'($urandom_range(0, 31));
        end
        else if (kind < 30)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    r.month = 4'd12;
                    r.day   = 5'd31;
                end
                1:
                begin
                    r.month = 4'd2;
                    r.day   = DAY_W'(days_in_month(32'(r.year), 2));
                end
                2:
                begin
                    r.month = 4'd1;
                    r.day   = 5'd1;
                end
                default:
                begin
                    r.month = 4'd12;
                    r.day   = DAY_W'($urandom_range(25, 31));
                end
            endcase
        end
        else
        begin
            r.month = MONTH_W'($urandom_range(1, 12));
            r.day   = DAY_W'($urandom_range(1, days_in_month(32'(r.year), 32'(r.month))));
        end
        case ($urandom_range(0, 9))
            0:          r.count = 15'd0;
            1, 2, 3, 4: r.count = COUNT_W'($urandom_range(1, 400));
            5, 6:       r.count = COUNT_W'($urandom_range(300, 800));
            7:          r.count = COUNT_W'($urandom_range(0, 4000));
            default:    r.count = COUNT_W'($urandom_range(0, 32767));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // send one request beat, with random idle cycles ahead of it
    task automatic drive_request(input date_req_t r, input logic known,
                                 input gdad_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.start_year  <= r.year;
        req_ch.start_month <= r.month;
        req_ch.start_day   <= r.day;
        req_ch.days_to_add <= r.count;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_dates.push_back(known ? want : advance_date(r));
    endtask

    // compare one result beat with the oldest predicted date
    task automatic check_date();
        gdad_result_t want;
        if (pending_dates.size() == 0)
        begin
            report_mismatch($sformatf("result %0d-%0d-%0d with nothing pending",
                                      rsp_ch.result_year, rsp_ch.result_month,
                                      rsp_ch.result_day));
            return;
        end
        want = pending_dates.pop_front();
        if (rsp_ch.result_year !== want.year)
            report_mismatch($sformatf("year %0d, want %0d", rsp_ch.result_year, want.year));
        if (rsp_ch.result_month !== want.month)
            report_mismatch($sformatf("month %0d, want %0d", rsp_ch.result_month, want.month));
        if (rsp_ch.result_day !== want.day)
            report_mismatch($sformatf("day %0d, want %0d", rsp_ch.result_day, want.day));
        if (rsp_ch.start_invalid !== want.invalid)
            report_mismatch($sformatf("invalid flag %0b, want %0b",
                                      rsp_ch.start_invalid, want.invalid));
    endtask

    // result side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                check_date();
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // stimulus and end of run
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        mismatches         = 0;
        send_idle_pct      = 28;
        recv_idle_pct      = 68;
        req_ch.valid       = 1'b0;
        req_ch.start_year  = '0;
        req_ch.start_month = '0;
        req_ch.start_day   = '0;
        req_ch.days_to_add = '0;
        rsp_ch.ready       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_N; i++)
            drive_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

        // random beats in three idle phases
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 28;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drive_request(random_request(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
